>>> sv/isf_pkg.sv
`default_nettype none
package isf_pkg;
  localparam int PosBits = 32;
  localparam int TotalBits = 33;
  localparam int FillBits = 7;

  typedef enum logic {
    CMD_MARK  = 1'b0,
    CMD_QUERY = 1'b1
  } cmd_t;

  typedef struct packed {
    logic load;
    logic commit;
  } isf_ctrl_t;

  typedef struct packed {
    logic busy;
  } isf_stat_t;
endpackage
`default_nettype wire

>>> sv/isf_ctrl.sv
`default_nettype none
module isf_ctrl
  import isf_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_fire,
  input  wire logic      out_free,
  output logic           in_ready,
  output isf_ctrl_t      ctrl
);
  typedef enum logic [1:0] {S_IDLE, S_EVAL, S_WAIT} state_t;
  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    ctrl = '0;
    in_ready = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_fire) begin
          ctrl.load = 1'b1;
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        if (out_free) begin
          ctrl.commit = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_WAIT;
        end
      end
      S_WAIT: begin
        if (out_free) begin
          ctrl.commit = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end
endmodule
`default_nettype wire

>>> sv/isf_dp.sv
`default_nettype none
module isf_dp
  import isf_pkg::*;
#(
  parameter int MAX_INTERVALS = 64,
  parameter int COORD_BITS = 32
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  isf_ctrl_t               ctrl,
  input  wire logic               in_cmd,
  input  wire logic [PosBits-1:0] in_pos,
  output logic [PosBits-1:0]      res_found,
  output logic                    res_covered,
  output logic                    res_full,
  output logic                    res_oor,
  output logic [TotalBits-1:0]    res_total,
  output logic [FillBits-1:0]     res_fill
);
  localparam int CB = (COORD_BITS > 32) ? 32 : COORD_BITS;
  localparam int CntBits = $clog2(MAX_INTERVALS + 1);
  localparam logic [32:0] Top = (33'd1 << CB) - 33'd1;

  // Cell chain: entries below fill are valid, kept sorted by start.
  logic [32:0] st_r [MAX_INTERVALS];
  logic [32:0] en_r [MAX_INTERVALS];
  logic [CntBits-1:0] fill_r;
  logic [TotalBits-1:0] total_r;
  logic cmd_r;
  logic [32:0] p_r;

  // Per-cell compare against the broadcast position.
  logic [MAX_INTERVALS-1:0] le_p, le_q, vld, cov_p, adj_l, adj_r, cov_q, is_l;
  logic [32:0] q;
  logic [32:0] qend;
  logic covered, jl, jr, hit_q;

  assign q = p_r + 33'd1;

  always_comb begin
    qend = '0;
    for (int i = 0; i < MAX_INTERVALS; i++) begin
      vld[i]   = CntBits'(i) < fill_r;
      le_p[i]  = vld[i] && st_r[i] <= p_r;
      le_q[i]  = vld[i] && st_r[i] <= q;
      cov_p[i] = le_p[i] && p_r <= en_r[i];
      cov_q[i] = le_q[i] && q <= en_r[i];
      adj_l[i] = vld[i] && en_r[i] + 33'd1 == p_r;
      adj_r[i] = vld[i] && st_r[i] == q;
      if (cov_q[i]) qend = qend | en_r[i];
    end
    // Last cell with start <= p is the only one that can cover or abut from below.
    for (int i = 0; i < MAX_INTERVALS; i++) begin
      is_l[i] = le_p[i] && ((i == MAX_INTERVALS - 1) ? 1'b1 : !le_p[(i + 1) % MAX_INTERVALS]);
    end
    covered = |cov_p;
    jl = |(adj_l & is_l);
    jr = |adj_r;
    hit_q = |cov_q;
  end

  logic do_new, full;
  assign full = !covered && !jl && !jr && fill_r >= CntBits'(MAX_INTERVALS);
  assign do_new = !covered && !jl && !jr && !full;

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      cmd_r <= in_cmd;
      p_r <= {1'b0, in_pos} & Top;
    end
    if (ctrl.commit && cmd_r == CMD_MARK && !covered) begin
      for (int i = 0; i < MAX_INTERVALS; i++) begin
        if (jl && jr) begin
          if (is_l[i]) en_r[i] <= en_r[(i + 1) % MAX_INTERVALS];
          else if (!le_p[i] && i + 1 < MAX_INTERVALS) begin
            st_r[i] <= st_r[(i + 1) % MAX_INTERVALS];
            en_r[i] <= en_r[(i + 1) % MAX_INTERVALS];
          end
        end else if (jl) begin
          if (is_l[i]) en_r[i] <= p_r;
        end else if (jr) begin
          if (adj_r[i]) st_r[i] <= p_r;
        end else if (do_new) begin
          if (!le_p[i]) begin
            if (i == 0 || le_p[(i + MAX_INTERVALS - 1) % MAX_INTERVALS]) begin
              st_r[i] <= p_r;
              en_r[i] <= p_r;
            end else begin
              st_r[i] <= st_r[(i + MAX_INTERVALS - 1) % MAX_INTERVALS];
              en_r[i] <= en_r[(i + MAX_INTERVALS - 1) % MAX_INTERVALS];
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
      total_r <= '0;
    end else if (ctrl.commit && cmd_r == CMD_MARK && !covered && !full) begin
      total_r <= total_r + TotalBits'(1);
      if (jl && jr) fill_r <= fill_r - CntBits'(1);
      else if (do_new) fill_r <= fill_r + CntBits'(1);
    end
  end

  logic [32:0] y;
  assign y = hit_q ? qend + 33'd1 : q;

  always_ff @(posedge clk) begin
    if (ctrl.commit) begin
      if (cmd_r == CMD_MARK) begin
        res_found <= p_r[31:0];
        res_covered <= covered;
        res_full <= full;
        res_oor <= 1'b0;
      end else begin
        res_covered <= 1'b0;
        res_full <= 1'b0;
        if (p_r >= Top || y > Top) begin
          res_oor <= 1'b1;
          res_found <= '0;
        end else begin
          res_oor <= 1'b0;
          res_found <= y[31:0];
        end
      end
    end
  end

  always_comb begin
    res_total = total_r;
    res_fill = FillBits'(fill_r);
  end
endmodule
`default_nettype wire

>>> sv/interval_set_mark_and_next_free_unit.sv
`default_nettype none
// Interval set with point mark and next-free query.
// Input beats on in_*: tuser is the command (0 mark, 1 query), tdata the position.
// Each input beat yields exactly one output beat on out_*.
// An item is registered when accepted and evaluated against all interval cells
// in parallel from the next cycle on; the chain of cells shifts on insert or
// merge when the result is committed. The output beat is registered at that
// commit, which waits in S_EVAL or S_WAIT until the output register is free,
// so a receiver stall delays both the result and the acceptance of the next
// item.
// The output beat is held in a register until taken; a new item is accepted
// only once the previous result has been loaded into that register, so at most
// one item waits in evaluation while one result waits for the receiver.
// Reset empties the table and clears the marked count; no clearing pass runs.
// out_tdata fields from bit 0: found_position[31:0], marked_total[64:32],
// intervals_used[71:65].
// out_tuser fields from bit 0: already_marked, table_full, out_of_range.
module interval_set_mark_and_next_free_unit
  import isf_pkg::*;
#(
  parameter int MAX_INTERVALS = 64,
  parameter int COORD_BITS = 32
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,   // position
  input  wire logic        in_tuser,   // cmd
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [71:0]      out_tdata,  // found_position, marked_total, intervals_used
  output logic [2:0]       out_tuser   // already_marked, table_full, out_of_range
);
  isf_ctrl_t ctrl;
  logic out_free, in_fire;
  logic [PosBits-1:0] found;
  logic cov, full, oor;
  logic [TotalBits-1:0] total;
  logic [FillBits-1:0] fill;
  logic ovalid_r;

  assign in_fire = in_tvalid && in_tready;
  assign out_free = !ovalid_r || out_tready;

  isf_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_fire(in_fire), .out_free(out_free),
    .in_ready(in_tready), .ctrl(ctrl)
  );

  isf_dp #(.MAX_INTERVALS(MAX_INTERVALS), .COORD_BITS(COORD_BITS)) u_dp (
    .clk(clk), .rst_n(rst_n), .ctrl(ctrl), .in_cmd(in_tuser), .in_pos(in_tdata),
    .res_found(found), .res_covered(cov), .res_full(full), .res_oor(oor),
    .res_total(total), .res_fill(fill)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovalid_r <= 1'b0;
    end else if (ctrl.commit) begin
      ovalid_r <= 1'b1;
    end else if (out_tready) begin
      ovalid_r <= 1'b0;
    end
  end

  assign out_tvalid = ovalid_r;
  assign out_tdata = {fill, total, found};
  assign out_tuser = {oor, full, cov};

  a_no_mark_oor: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tuser[2] && (out_tuser[0] || out_tuser[1])))
    else $error("query and mark flags together");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result lost under stall");
  a_single: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second item taken while busy");
endmodule
`default_nettype wire

>>> tb/sv/tb_interval_set_mark_and_next_free_unit.sv
`timescale 1ns / 1ps
module tb_interval_set_mark_and_next_free_unit;
  import isf_pkg::*;

  localparam int TableDepth = 64;

  typedef struct {
    logic [31:0] found_position;
    logic        already_marked;
    logic        table_full;
    logic        out_of_range;
    logic [32:0] marked_total;
    logic [6:0]  intervals_used;
  } mark_result_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;   // position
  logic        in_tuser;   // cmd
  logic        out_tvalid;
  logic        out_tready;
  logic [71:0] out_tdata;  // found_position, marked_total, intervals_used
  logic [2:0]  out_tuser;  // already_marked, table_full, out_of_range

  interval_set_mark_and_next_free_unit u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser)
  );

  // Predictor state: sorted disjoint intervals and the marked count.
  logic [31:0] span_lo [TableDepth];
  logic [31:0] span_hi [TableDepth];
  int          span_count;
  logic [32:0] marked_cells;

  mark_result_t pending_results[$];
  int  mismatch_count;
  bit  quiet_phase;
  bit  recv_hold;
  int  recv_hold_cycles;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic int last_start_at_or_below(logic [32:0] p);
    int k;
    k = -1;
    for (int i = 0; i < span_count; i++) begin
      if ({1'b0, span_lo[i]} <= p) k = i;
      else break;
    end
    return k;
  endfunction

  function automatic mark_result_t predict_item(cmd_t cmd, logic [31:0] pos);
    mark_result_t r;
    int li;
    int ri;
    bit jl;
    bit jr;
    logic [32:0] y;
    r = '{default: '0};
    li = last_start_at_or_below({1'b0, pos});
    if (cmd == CMD_MARK) begin
      r.found_position = pos;
      ri = li + 1;
      if (li >= 0 && pos <= span_hi[li]) begin
        r.already_marked = 1'b1;
      end else begin
        jl = li >= 0 && ({1'b0, span_hi[li]} + 33'd1) == {1'b0, pos};
        jr = ri < span_count && {1'b0, span_lo[ri]} == {1'b0, pos} + 33'd1;
        if (jl && jr) begin
          span_hi[li] = span_hi[ri];
          for (int i = ri; i + 1 < span_count; i++) begin
            span_lo[i] = span_lo[i + 1];
            span_hi[i] = span_hi[i + 1];
          end
          span_count--;
          marked_cells++;
        end else if (jl) begin
          span_hi[li] = pos;
          marked_cells++;
        end else if (jr) begin
          span_lo[ri] = pos;
          marked_cells++;
        end else if (span_count >= TableDepth) begin
          r.table_full = 1'b1;
        end else begin
          for (int i = span_count; i > ri; i--) begin
            span_lo[i] = span_lo[i - 1];
            span_hi[i] = span_hi[i - 1];
          end
          span_lo[ri] = pos;
          span_hi[ri] = pos;
          span_count++;
          marked_cells++;
        end
      end
    end else begin
      if (pos == 32'hFFFF_FFFF) begin
        r.out_of_range = 1'b1;
      end else begin
        y = {1'b0, pos} + 33'd1;
        li = last_start_at_or_below(y);
        if (li >= 0 && y <= {1'b0, span_hi[li]}) y = {1'b0, span_hi[li]} + 33'd1;
        if (y[32]) r.out_of_range = 1'b1;
        else r.found_position = y[31:0];
      end
    end
    r.marked_total = marked_cells;
    r.intervals_used = span_count[6:0];
    return r;
  endfunction

  task automatic send_item(cmd_t cmd, logic [31:0] pos);
    int gap;
    if (!quiet_phase && $urandom_range(3) == 0) begin
      gap = $urandom_range(16, 1);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= pos;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_results.push_back(predict_item(cmd, pos));
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Receiver stalls: random bursts, plus a long forced hold.
  initial begin
    int burst;
    out_tready = 1'b0;
    @(posedge rst_n);
    forever begin
      if (recv_hold) begin
        out_tready <= 1'b0;
        repeat (recv_hold_cycles) @(posedge clk);
        recv_hold = 1'b0;
      end else if (!quiet_phase && $urandom_range(3) == 0) begin
        burst = $urandom_range(16, 1);
        out_tready <= 1'b0;
        repeat (burst) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    mark_result_t e;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("unexpected result beat %h", out_tdata);
      end else begin
        e = pending_results.pop_front();
        if (out_tdata[31:0] !== e.found_position || out_tdata[64:32] !== e.marked_total ||
            out_tdata[71:65] !== e.intervals_used || out_tuser[0] !== e.already_marked ||
            out_tuser[1] !== e.table_full || out_tuser[2] !== e.out_of_range) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch: exp pos=%h tot=%0d n=%0d fl=%b%b%b got pos=%h tot=%0d n=%0d fl=%b",
                     e.found_position, e.marked_total, e.intervals_used, e.out_of_range,
                     e.table_full, e.already_marked, out_tdata[31:0], out_tdata[64:32],
                     out_tdata[71:65], out_tuser);
        end
      end
    end
  end

  task automatic test_extremes();
    send_item(CMD_QUERY, 32'h0000_0000);
    send_item(CMD_QUERY, 32'hFFFF_FFFF);
    send_item(CMD_MARK, 32'hFFFF_FFFF);
    send_item(CMD_QUERY, 32'hFFFF_FFFE);
    send_item(CMD_MARK, 32'h0000_0000);
    send_item(CMD_MARK, 32'h0000_0000);
    send_item(CMD_MARK, 32'h0000_0002);
    send_item(CMD_MARK, 32'h0000_0001);   // joins both neighbors
    send_item(CMD_MARK, 32'h0000_0004);
    send_item(CMD_MARK, 32'h0000_0003);
    send_item(CMD_MARK, 32'h0000_0006);
    send_item(CMD_MARK, 32'h0000_0007);   // extends left neighbor
    send_item(CMD_MARK, 32'h0000_0005);
    send_item(CMD_QUERY, 32'h0000_0000);
    send_item(CMD_MARK, 32'hFFFF_FFFD);
    send_item(CMD_MARK, 32'hFFFF_FFFE);
    send_item(CMD_QUERY, 32'hFFFF_FFF0);  // next free cell lies below the marked top cells
    send_item(CMD_MARK, 32'hAAAA_AAAA);
    send_item(CMD_MARK, 32'h5555_5555);
    send_item(CMD_QUERY, 32'h5555_5554);
    drain_results();
  endtask

  task automatic test_table_full();
    // Spaced cells fill the table, then new isolated cells must be dropped.
    for (int i = 0; i < 70; i++) send_item(CMD_MARK, 32'h1000_0000 + i * 4);
    send_item(CMD_MARK, 32'h1000_0001);   // merge still works when full
    send_item(CMD_MARK, 32'h2000_0000);
    drain_results();
  endtask

  task automatic test_backpressure();
    recv_hold_cycles = 200;
    recv_hold = 1'b1;
    for (int i = 0; i < 20; i++) send_item(cmd_t'($urandom_range(1)), $urandom);
    drain_results();
  endtask

  task automatic test_random(int count, bit dense);
    logic [31:0] base;
    logic [31:0] p;
    base = $urandom;
    for (int i = 0; i < count; i++) begin
      if (dense) p = base + $urandom_range(150);
      else if ($urandom_range(9) == 0) p = $urandom;
      else p = base + $urandom_range(2000);
      send_item(cmd_t'($urandom_range(2) == 0), p);
      if (i % 300 == 299) base = $urandom;
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = 1'b0;
    mismatch_count = 0;
    quiet_phase = 1'b0;
    recv_hold = 1'b0;
    recv_hold_cycles = 0;
    span_count = 0;
    marked_cells = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_extremes();
    test_table_full();
    test_backpressure();
    test_random(800, 1'b1);
    drain_results();
    test_random(600, 1'b0);
    quiet_phase = 1'b1;
    test_random(300, 1'b1);
    drain_results();
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("[FAIL] regression broken");
    $finish;
  end
endmodule

>>> interval_set_mark_and_next_free_unit.f
sv/isf_pkg.sv
sv/isf_ctrl.sv
sv/isf_dp.sv
sv/interval_set_mark_and_next_free_unit.sv
tb/sv/tb_interval_set_mark_and_next_free_unit.sv
